/* src/tosv_pkg.sv */
package tosv_pkg;

  localparam int CMD_W    = 2;
  localparam int NOTE_W   = 7;
  localparam int LEVEL_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int MIX_W    = 33;
  localparam int GAIN_W   = 15;
  localparam int SINE_W   = 15;
  localparam int NOTE_CNT = 128;

  localparam int DEF_PHASE_BITS       = 32;
  localparam int DEF_SINE_TABLE_DEPTH = 1024;
  localparam int DEF_SAMPLE_RATE      = 48000;

  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd2;

  localparam logic REG_SQUARE_LEVEL = 1'b0;
  localparam logic REG_SINE_LEVEL   = 1'b1;

  // 0.3 in q0.16
  localparam logic [GAIN_W-1:0] NOTE_GAIN = 15'd19661;

  // 2^(m/12) in q2.30
  localparam logic [31:0] SEMITONE_Q30 [12] = '{
    32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
    32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
    32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
  };

  typedef struct packed {
    logic                    valid;
    logic signed [MIX_W-1:0] mix;
    logic                    gate;
  } mix_item_t;

  // q30 product, truncated toward zero
  function automatic longint mul_q30(longint a, longint b);
    longint m;
    begin
      if (a < 0) begin
        m = -(((-a) * b) >>> 30);
      end else begin
        m = (a * b) >>> 30;
      end
      return m;
    end
  endfunction

  // sin(pi/2 * z) for z in q30 on [0,1], scaled to 0..32767
  function automatic logic [SINE_W-1:0] sine_mag(longint z);
    longint z2;
    longint p;
    longint s;
    longint v;
    begin
      z2 = (z * z) >>> 30;
      p  = 64'sd172272;
      p  = mul_q30(p, z2) - 64'sd5026995;
      p  = mul_q30(p, z2) + 64'sd85569306;
      p  = mul_q30(p, z2) - 64'sd693598668;
      p  = mul_q30(p, z2) + 64'sd1686629713;
      s  = mul_q30(p, z);
      if (s <= 0) begin
        v = 0;
      end else begin
        v = (s * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
      end
      if (v > 64'sd32767) begin
        v = 64'sd32767;
      end
      return v[SINE_W-1:0];
    end
  endfunction

endpackage

/* src/tosv_if.sv */
interface tosv_in_if;
  import tosv_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [NOTE_W-1:0] note;
  modport source(output valid, output cmd, output note, input ready);
  modport sink(input valid, input cmd, input note, output ready);
endinterface

interface tosv_out_if;
  import tosv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

/* src/tosv_regs.sv */
module tosv_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [tosv_pkg::LEVEL_W-1:0]  square_level,
  output logic [tosv_pkg::LEVEL_W-1:0]  sine_level
);
  import tosv_pkg::*;

  logic [LEVEL_W-1:0] square_level_r, square_level_nxt;
  logic [LEVEL_W-1:0] sine_level_r, sine_level_nxt;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    square_level_nxt = square_level_r;
    sine_level_nxt   = sine_level_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_SQUARE_LEVEL: square_level_nxt = pwdata[LEVEL_W-1:0];
        REG_SINE_LEVEL:   sine_level_nxt   = pwdata[LEVEL_W-1:0];
        default:          square_level_nxt = square_level_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SQUARE_LEVEL: prdata = {16'd0, square_level_r};
      REG_SINE_LEVEL:   prdata = {16'd0, sine_level_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_level_r <= '0;
      sine_level_r   <= '0;
    end else begin
      square_level_r <= square_level_nxt;
      sine_level_r   <= sine_level_nxt;
    end
  end

  assign square_level = square_level_r;
  assign sine_level   = sine_level_r;

endmodule

/* src/tosv_osc.sv */
module tosv_osc #(
  parameter int PHASE_BITS       = tosv_pkg::DEF_PHASE_BITS,
  parameter int SINE_TABLE_DEPTH = tosv_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int SAMPLE_RATE      = tosv_pkg::DEF_SAMPLE_RATE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tosv_pkg::CMD_W-1:0]    in_cmd,
  input  logic [tosv_pkg::NOTE_W-1:0]   in_note,
  input  logic [tosv_pkg::LEVEL_W-1:0]  square_level,
  input  logic [tosv_pkg::LEVEL_W-1:0]  sine_level,
  output tosv_pkg::mix_item_t           mix_item,
  input  logic                          mix_ready
);
  import tosv_pkg::*;

  localparam int LD = $clog2(SINE_TABLE_DEPTH);
  localparam int QB = LD - 2;
  localparam int QD = SINE_TABLE_DEPTH / 4;

  typedef logic [PHASE_BITS-1:0] step_rom_t [NOTE_CNT];
  typedef logic [SINE_W-1:0]     sine_rom_t [QD];

  // step = round(55 * 2^(m/12) * 2^(o + PHASE_BITS - 3) / rate), note + 3 = 12*o + m
  function automatic step_rom_t build_steps();
    step_rom_t          r;
    longint unsigned    num;
    longint unsigned    q;
    int                 d;
    int                 s;
    begin
      for (int n = 0; n < NOTE_CNT; n++) begin
        d   = n + 3;
        s   = d / 12 + PHASE_BITS - 33;
        num = 64'd55 * longint'(SEMITONE_Q30[d % 12]);
        if (s >= 0) begin
          q = ((num << s) + longint'(SAMPLE_RATE / 2)) / SAMPLE_RATE;
        end else begin
          q = ((num + (longint'(SAMPLE_RATE) << (-s - 1))) / SAMPLE_RATE) >> (-s);
        end
        r[n] = q[PHASE_BITS-1:0];
      end
      return r;
    end
  endfunction

  // first quadrant of the sine, one entry per table step
  function automatic sine_rom_t build_sine();
    sine_rom_t r;
    begin
      for (int k = 0; k < QD; k++) begin
        r[k] = sine_mag(longint'(k) <<< (32 - LD));
      end
      return r;
    end
  endfunction

  localparam step_rom_t           STEP_ROM = build_steps();
  localparam sine_rom_t           SINE_ROM = build_sine();
  localparam logic [SINE_W-1:0]   SINE_TOP = sine_mag(64'sd1 <<< 30);

  logic                   s1_valid_r, s1_valid_nxt;
  logic [CMD_W-1:0]       s1_cmd_r;
  logic [NOTE_W-1:0]      s1_note_r;
  logic [PHASE_BITS-1:0]  square_phase_r, square_phase_nxt;
  logic [PHASE_BITS-1:0]  sine_phase_r, sine_phase_nxt;
  logic [PHASE_BITS-1:0]  phase_step_r, phase_step_nxt;
  logic                   gate_r, gate_nxt;
  mix_item_t              s2_r, s2_nxt;

  logic                   s2_free;
  logic                   s1_adv;
  logic                   in_xfer;
  logic [LD-1:0]          sidx;
  logic [1:0]             quad;
  logic [QB-1:0]          k_fwd;
  logic [QB-1:0]          k_mir;
  logic [SINE_W-1:0]      smag;
  logic signed [15:0]     sine_val;
  logic signed [MIX_W-1:0] sine_term;
  logic signed [MIX_W-1:0] sq_term;
  logic                   sq_edge;

  assign s2_free  = !s2_r.valid || mix_ready;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;
  assign in_xfer  = in_valid && in_ready;

  // sine lookup with quarter-wave symmetry
  assign sidx  = sine_phase_r[PHASE_BITS-1 -: LD];
  assign quad  = sidx[LD-1 -: 2];
  assign k_fwd = sidx[QB-1:0];
  assign k_mir = ~k_fwd + QB'(1);

  always_comb begin
    if (!quad[0]) begin
      smag = SINE_ROM[k_fwd];
    end else if (k_fwd == '0) begin
      smag = SINE_TOP;
    end else begin
      smag = SINE_ROM[k_mir];
    end
    sine_val = quad[1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
  end

  assign sine_term = MIX_W'($signed({1'b0, sine_level})) * MIX_W'(sine_val);

  // square is zero exactly at phase 0 and at the half turn
  assign sq_edge = (square_phase_r[PHASE_BITS-2:0] == '0);

  always_comb begin
    if (sq_edge) begin
      sq_term = '0;
    end else if (!square_phase_r[PHASE_BITS-1]) begin
      sq_term = $signed({2'b00, square_level, 15'd0});
    end else begin
      sq_term = -$signed({2'b00, square_level, 15'd0});
    end
  end

  always_comb begin
    square_phase_nxt = square_phase_r;
    sine_phase_nxt   = sine_phase_r;
    phase_step_nxt   = phase_step_r;
    gate_nxt         = gate_r;
    s2_nxt           = s2_r;
    s1_valid_nxt     = s1_valid_r;
    if (s2_free) begin
      s2_nxt.valid = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      case (s1_cmd_r)
        CMD_TICK: begin
          s2_nxt.valid     = 1'b1;
          s2_nxt.mix       = sq_term + sine_term;
          s2_nxt.gate      = gate_r;
          square_phase_nxt = square_phase_r + {phase_step_r[PHASE_BITS-2:0], 1'b0};
          sine_phase_nxt   = sine_phase_r + phase_step_r;
        end
        CMD_NOTE_ON: begin
          phase_step_nxt   = STEP_ROM[s1_note_r];
          square_phase_nxt = '0;
          sine_phase_nxt   = '0;
          gate_nxt         = 1'b1;
        end
        CMD_NOTE_OFF: begin
          gate_nxt = 1'b0;
        end
        default: begin
          gate_nxt = gate_r;
        end
      endcase
    end
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      square_phase_r <= '0;
      sine_phase_r   <= '0;
      phase_step_r   <= '0;
      gate_r         <= 1'b0;
      s2_r           <= '0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      square_phase_r <= square_phase_nxt;
      sine_phase_r   <= sine_phase_nxt;
      phase_step_r   <= phase_step_nxt;
      gate_r         <= gate_nxt;
      s2_r           <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r  <= in_cmd;
      s1_note_r <= in_note;
    end
  end

  assign mix_item = s2_r;

  a_note_on_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r == CMD_NOTE_ON) |=>
      (square_phase_r == '0 && sine_phase_r == '0 && gate_r))
    else $error("note on did not clear phases and open gate");

  a_note_off_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r == CMD_NOTE_OFF) |=> !gate_r)
    else $error("note off left gate open");

  a_only_ticks_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r != CMD_TICK) |=> !s2_r.valid)
    else $error("non-tick item produced a sample");

  a_unused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r != CMD_TICK && s1_cmd_r != CMD_NOTE_ON) |=>
      ($stable(sine_phase_r) && $stable(square_phase_r) && $stable(phase_step_r)))
    else $error("phase state moved without tick or note on");

endmodule

/* src/tosv_mix.sv */
module tosv_mix (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tosv_pkg::mix_item_t                  mix_item,
  output logic                                 mix_ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tosv_pkg::SAMPLE_W-1:0] out_sample
);
  import tosv_pkg::*;

  localparam int PROD_W = MIX_W - 1 + GAIN_W;

  logic                        s3_valid_r, s3_valid_nxt;
  logic [PROD_W-1:0]           s3_prod_r;
  logic                        s3_neg_r;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0]  out_sample_r, out_sample_nxt;

  logic                        out_free;
  logic                        s3_adv;
  logic [MIX_W-2:0]            mix_mag;
  logic [GAIN_W-1:0]           gain;
  logic [PROD_W:0]             rsum;
  logic [SAMPLE_W-1:0]         rmag;

  assign out_free  = !out_valid_r || out_ready;
  assign s3_adv    = s3_valid_r && out_free;
  assign mix_ready = !s3_valid_r || out_free;

  assign mix_mag = mix_item.mix[MIX_W-1] ? (MIX_W-1)'(-mix_item.mix)
                                         : mix_item.mix[MIX_W-2:0];
  assign gain    = mix_item.gate ? NOTE_GAIN : '0;

  // q47 to q15, ties away from zero via sign-magnitude rounding
  assign rsum = {1'b0, s3_prod_r} + ((PROD_W+1)'(1) << 31);
  assign rmag = rsum[PROD_W -: SAMPLE_W];

  always_comb begin
    if (s3_neg_r) begin
      out_sample_nxt = (rmag > 16'd32768) ? 16'sh8000 : -$signed(rmag);
    end else begin
      out_sample_nxt = (rmag > 16'd32767) ? 16'sh7fff : $signed(rmag);
    end
  end

  always_comb begin
    s3_valid_nxt  = s3_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s3_valid_r;
    end
    if (mix_ready) begin
      s3_valid_nxt = mix_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s3_valid_r  <= s3_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_ready && mix_item.valid) begin
      s3_prod_r <= PROD_W'(mix_mag) * PROD_W'(gain);
      s3_neg_r  <= mix_item.mix[MIX_W-1];
    end
    if (s3_adv) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  a_closed_gate_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mix_ready && mix_item.valid && !mix_item.gate) |=> (s3_prod_r == '0))
    else $error("closed gate gave nonzero product");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_sample_r)))
    else $error("stalled sample changed");

  a_s3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && !out_free) |=> (s3_valid_r && $stable(s3_prod_r)))
    else $error("stalled product changed");

endmodule

/* src/two_osc_synth_voice.sv */
// channel  dir  transfer when           payload
// in_if    in   in_if.valid&in_if.ready  cmd[1:0], note[6:0]
// out_if   out  out_if.valid&out_if.ready sample[15:0] signed q1.15
// cfg_*    in   psel&penable&pwrite      square_level @0x0, sine_level @0x4
//
// one item per cycle while the output is not stalled; a tick's sample reaches the output
// register through the input register, mix stage, gain stage and output register
// note on/off and unused commands use one slot and give no sample
// synchronous active-low reset clears phases, step, gate, levels and all valids
// each stage holds while the next is full, so input keeps flowing until the
// pipeline behind a stalled output has filled
module two_osc_synth_voice #(
  parameter int PHASE_BITS       = tosv_pkg::DEF_PHASE_BITS,
  parameter int SINE_TABLE_DEPTH = tosv_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int SAMPLE_RATE      = tosv_pkg::DEF_SAMPLE_RATE
) (
  input  logic              clk,
  input  logic              rst_n,
  tosv_in_if.sink           in_if,
  tosv_out_if.source        out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import tosv_pkg::*;

  logic [LEVEL_W-1:0] square_level;
  logic [LEVEL_W-1:0] sine_level;
  mix_item_t          mix_item;
  logic               mix_ready;

  tosv_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .square_level (square_level),
    .sine_level   (sine_level)
  );

  tosv_osc #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_RATE      (SAMPLE_RATE)
  ) u_osc (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_cmd       (in_if.cmd),
    .in_note      (in_if.note),
    .square_level (square_level),
    .sine_level   (sine_level),
    .mix_item     (mix_item),
    .mix_ready    (mix_ready)
  );

  tosv_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .mix_item   (mix_item),
    .mix_ready  (mix_ready),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_sample (out_if.sample)
  );

endmodule

/* test/tb_two_osc_synth_voice.sv */
`timescale 1ns / 1ps

module tb_two_osc_synth_voice;
  import tosv_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_SQUARE = {REG_SQUARE_LEVEL, 2'b00};
  localparam logic [2:0] ADDR_SINE   = {REG_SINE_LEVEL, 2'b00};
  localparam int PH_W = DEF_PHASE_BITS;
  localparam logic [PH_W-1:0] HALF_TURN = {1'b1, {(PH_W-1){1'b0}}};
  localparam longint unsigned GAIN_OPEN = 19661;
  localparam longint unsigned Q30 = 64'd1 << 30;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;

  // 2^(m/12) in q2.30
  localparam longint unsigned SEMI_RATIO [12] = '{
    1073741824, 1137589835, 1205234447, 1276901417,
    1352829926, 1433273380, 1518500250, 1608794974,
    1704458901, 1805811301, 1913190429, 2026954652
  };

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NOTE_W-1:0] note;
  } voice_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  tosv_in_if  in_ch ();
  tosv_out_if out_ch ();

  two_osc_synth_voice dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // voice state as the block should hold it
  logic [LEVEL_W-1:0] square_lvl;
  logic [LEVEL_W-1:0] sine_lvl;
  logic [PH_W-1:0] square_ph;
  logic [PH_W-1:0] sine_ph;
  logic [PH_W-1:0] step;
  logic gate;

  voice_cmd_t cmd_fifo [$];
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int errors;
  int queued_items;
  bit idle_on;
  int in_gap;
  int out_gap;
  int stall_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endtask

  function automatic logic [PH_W-1:0] step_for_note(logic [NOTE_W-1:0] n);
    longint unsigned d;
    longint unsigned o;
    longint unsigned num;
    longint unsigned dv;
    int sh;
    d = n;
    d = d + 3;
    o = d / 12;
    num = 55 * SEMI_RATIO[d % 12];
    dv = DEF_SAMPLE_RATE;
    sh = int'(o) + PH_W - 33;
    if (sh >= 0) begin
      num = num << sh;
    end else begin
      dv = dv << (-sh);
    end
    return PH_W'((num + dv / 2) / dv);
  endfunction

  // q30 product with truncation toward zero
  function automatic longint q30_scale(longint a, longint b);
    if (a < 0) begin
      return -(((-a) * b) >>> 30);
    end
    return (a * b) >>> 30;
  endfunction

  function automatic longint sine_lookup(logic [PH_W-1:0] ph);
    longint unsigned top;
    longint unsigned idx;
    longint unsigned u;
    longint unsigned quad;
    longint unsigned t;
    longint unsigned z;
    longint unsigned z2;
    longint p;
    longint s;
    longint v;
    top = ph >> (PH_W - 16);
    idx = (top * DEF_SINE_TABLE_DEPTH) >> 16;
    u = (idx << 32) / DEF_SINE_TABLE_DEPTH;
    quad = (u >> 30) & 3;
    t = u & (Q30 - 1);
    z = quad[0] ? (Q30 - t) : t;
    z2 = (z * z) >> 30;
    p = 172272;
    p = q30_scale(p, longint'(z2)) - 5026995;
    p = q30_scale(p, longint'(z2)) + 85569306;
    p = q30_scale(p, longint'(z2)) - 693598668;
    p = q30_scale(p, longint'(z2)) + 1686629713;
    s = q30_scale(p, longint'(z));
    if (s <= 0) begin
      v = 0;
    end else begin
      v = (s * 32767 + (longint'(1) <<< 29)) >>> 30;
    end
    if (v > 32767) begin
      v = 32767;
    end
    return quad[1] ? -v : v;
  endfunction

  task automatic advance_voice(input logic [CMD_W-1:0] cmd, input logic [NOTE_W-1:0] note);
    longint sq;
    longint mixv;
    longint unsigned mag;
    longint unsigned gain;
    longint r;
    case (cmd)
      CMD_NOTE_ON: begin
        step = step_for_note(note);
        square_ph = '0;
        sine_ph = '0;
        gate = 1'b1;
      end
      CMD_NOTE_OFF: begin
        gate = 1'b0;
      end
      CMD_TICK: begin
        if (square_ph == '0 || square_ph == HALF_TURN) begin
          sq = 0;
        end else if (square_ph < HALF_TURN) begin
          sq = longint'(square_lvl) * 32768;
        end else begin
          sq = -(longint'(square_lvl) * 32768);
        end
        mixv = sq + longint'(sine_lvl) * sine_lookup(sine_ph);
        gain = gate ? GAIN_OPEN : 0;
        mag = (mixv < 0) ? longint'(-mixv) : longint'(mixv);
        mag = (mag * gain + (64'd1 << 31)) >> 32;
        r = (mixv < 0) ? -longint'(mag) : longint'(mag);
        if (r > 32767) begin
          r = 32767;
        end
        if (r < -32768) begin
          r = -32768;
        end
        expected_samples.push_back(r[SAMPLE_W-1:0]);
        square_ph = square_ph + (step << 1);
        sine_ph = sine_ph + step;
      end
      default: begin
      end
    endcase
  endtask

  // input driver
  always @(posedge clk) begin
    voice_cmd_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_voice(in_ch.cmd, in_ch.note);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (idle_on && cmd_fifo.size() != 0 && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 9);
          in_ch.valid <= 1'b0;
        end else if (cmd_fifo.size() != 0) begin
          it = cmd_fifo.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= it.cmd;
          in_ch.note <= it.note;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink backpressure
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          report_error($sformatf("unexpected sample %0d", out_ch.sample));
        end else begin
          want = expected_samples.pop_front();
          if (out_ch.sample !== want) begin
            report_error($sformatf("sample mismatch: got %0d, want %0d",
                                   out_ch.sample, want));
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[two_osc_synth_voice] ERROR");
        $finish;
      end
    end
  end

  task automatic write_level(input logic [2:0] addr, input logic [LEVEL_W-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_SQUARE) begin
      square_lvl = value;
    end else begin
      sine_lvl = value;
    end
  endtask

  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [NOTE_W-1:0] note);
    cmd_fifo.push_back('{cmd: cmd, note: note});
    if (cmd != CMD_UNUSED) begin
      queued_items++;
    end
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_item(CMD_TICK, NOTE_W'($urandom));
  endtask

  // sender holds off until the pipeline is empty
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_fifo.size() != 0 || in_ch.valid || expected_samples.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input logic [LEVEL_W-1:0] sq, input logic [LEVEL_W-1:0] sn,
                            input int n_items);
    int kind;
    logic [NOTE_W-1:0] n;
    wait_drained();
    write_level(ADDR_SQUARE, sq);
    write_level(ADDR_SINE, sn);
    @(negedge clk);
    queued_items = 0;
    while (queued_items < n_items) begin
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        // well-formed note: on, a run of ticks, maybe off and release ticks
        if ($urandom_range(0, 7) == 0) begin
          n = $urandom_range(0, 1) ? 7'd127 : 7'd0;
        end else begin
          n = NOTE_W'($urandom_range(0, 127));
        end
        push_item(CMD_NOTE_ON, n);
        push_ticks(($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24));
        if ($urandom_range(0, 2) == 0) begin
          push_item(CMD_NOTE_OFF, NOTE_W'($urandom));
          push_ticks($urandom_range(0, 3));
        end
      end else if (kind < 17) begin
        push_item(CMD_UNUSED, NOTE_W'($urandom));
      end else if (kind < 19) begin
        push_item(CMD_NOTE_OFF, NOTE_W'($urandom));
      end else begin
        push_ticks($urandom_range(1, 5));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TICK;
    in_ch.note = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    idle_on = 1'b1;
    square_lvl = '0;
    sine_lvl = '0;
    square_ph = '0;
    sine_ph = '0;
    step = '0;
    gate = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: closed gate, unused command, lowest, highest and a440 notes
    write_level(ADDR_SQUARE, 16'hFFFF);
    write_level(ADDR_SINE, 16'hFFFF);
    @(negedge clk);
    push_item(CMD_TICK, 7'd0);
    push_item(CMD_NOTE_OFF, 7'd0);
    push_item(CMD_UNUSED, 7'd127);
    push_item(CMD_TICK, 7'd127);
    push_item(CMD_NOTE_ON, 7'd0);
    push_ticks(3);
    push_item(CMD_NOTE_ON, 7'd127);
    push_ticks(3);
    push_item(CMD_NOTE_ON, 7'd69);
    push_ticks(5);
    push_item(CMD_UNUSED, 7'd0);
    push_item(CMD_TICK, 7'd0);
    push_item(CMD_NOTE_OFF, 7'd127);
    push_ticks(2);

    run_random(16'd0, 16'hFFFF, 260);
    run_random(16'hFFFF, 16'd0, 260);
    run_random(16'd0, 16'd0, 60);
    run_random(16'($urandom), 16'($urandom), 260);
    run_random(16'hFFFF, 16'hFFFF, 200);
    wait_drained();
    idle_on = 1'b0;
    run_random(16'($urandom), 16'($urandom), 260);
    wait_drained();

    if (errors == 0) begin
      $display("[two_osc_synth_voice] OK");
    end else begin
      $display("[two_osc_synth_voice] ERROR");
    end
    $finish;
  end

endmodule
